// ===== hw/rtl/oal_pkg.sv =====
// Shared types and codes for the ordered array list.
// Request and result payload structs, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps

package oal_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [4:0]         position;
        logic signed [31:0] item_value;
    } t_in_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_index;
        logic [4:0] list_length;
    } t_out_req;

    typedef struct packed {
        logic     done;
        t_out_req res;
    } t_seq_res;

endpackage

// ===== hw/rtl/oal_mem.sv =====
// Entry storage for the ordered array list.
// One write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module oal_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/oal_seq.sv =====
// Request sequencer for the ordered array list.
// Decodes a request, walks the entry memory to shift or compare, builds the result.
// Depends on oal_pkg.
`timescale 1ns / 1ps

module oal_seq
    import oal_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in_req       i_in_req,
    input  logic          i_take,
    output t_seq_res      o_seq_res,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [31:0]   o_mem_wdata,
    output logic          o_mem_re,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [31:0]   i_mem_rdata
);

    localparam int PW = (CW > 5) ? CW : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_more, n_more;
    logic          r_pend, n_pend;
    logic [1:0]    r_op, n_op;
    logic [AW-1:0] r_pos, n_pos;
    logic [31:0]   r_val, n_val;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_waddr, n_waddr;
    logic [1:0]    r_st, n_st;
    logic [AW-1:0] r_idx, n_idx;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic [AW-1:0] in_pos;
    logic [AW-1:0] last;
    logic          stop_rd;

    assign pos_ext = PW'(i_in_req.position);
    assign cnt_ext = PW'(r_cnt);
    assign in_pos  = AW'(pos_ext);
    assign last    = AW'(r_cnt - CW'(1));
    assign stop_rd = (r_op == OP_INSERT) ? (r_ptr == r_pos) : (r_ptr == last);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_more      = r_more;
        n_pend      = r_pend;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_ptr       = r_ptr;
        n_waddr     = r_waddr;
        n_st        = r_st;
        n_idx       = r_idx;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_waddr;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op   = i_in_req.func;
                    n_pos  = in_pos;
                    n_val  = i_in_req.item_value;
                    n_more = 1'b1;
                    n_pend = 1'b0;
                    n_st   = ST_DONE;
                    n_idx  = '0;
                    n_state = S_FIN;
                    case (i_in_req.func)
                        OP_INSERT: begin
                            if (r_cnt >= CW'(CAPACITY)) begin
                                n_st = ST_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                n_st = ST_BADPOS;
                            end else if (pos_ext == cnt_ext) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = in_pos;
                                o_mem_wdata = i_in_req.item_value;
                                n_cnt       = r_cnt + CW'(1);
                            end else begin
                                n_ptr   = last;
                                n_state = S_SCAN;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_st = ST_BADPOS;
                            end else if (pos_ext == cnt_ext - PW'(1)) begin
                                n_cnt = r_cnt - CW'(1);
                            end else begin
                                n_ptr   = in_pos + AW'(1);
                                n_state = S_SCAN;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_cnt == '0) begin
                                n_st = ST_NOTFOUND;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_st = ST_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_more) begin
                    o_mem_re = 1'b1;
                    n_pend   = 1'b1;
                    case (r_op)
                        OP_INSERT: n_waddr = r_ptr + AW'(1);
                        OP_DELETE: n_waddr = r_ptr - AW'(1);
                        default:   n_waddr = r_ptr;
                    endcase
                    if (stop_rd) begin
                        n_more = 1'b0;
                    end else if (r_op == OP_INSERT) begin
                        n_ptr = r_ptr - AW'(1);
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_op == OP_SEARCH) begin
                        if (i_mem_rdata == r_val) begin
                            n_st    = ST_DONE;
                            n_idx   = r_waddr;
                            n_state = S_FIN;
                        end else if (!r_more) begin
                            n_st    = ST_NOTFOUND;
                            n_state = S_FIN;
                        end
                    end else begin
                        o_mem_we = 1'b1;
                        if (!r_more) begin
                            if (r_op == OP_INSERT) begin
                                n_state = S_PUT;
                            end else begin
                                n_cnt   = r_cnt - CW'(1);
                                n_state = S_FIN;
                            end
                        end
                    end
                end
            end
            S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos;
                o_mem_wdata = r_val;
                n_cnt       = r_cnt + CW'(1);
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_seq_res.done                = (r_state == S_FIN);
        o_seq_res.res.status          = r_st;
        o_seq_res.res.found_index     = 4'(r_idx);
        o_seq_res.res.list_length     = 5'(r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_more  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_more  <= n_more;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_ptr   <= n_ptr;
        r_waddr <= n_waddr;
        r_st    <= n_st;
        r_idx   <= n_idx;
    end

endmodule

// ===== hw/rtl/ordered_array_list.sv =====
// Top level of the ordered array list: sequencer, entry memory, result register.
// Depends on oal_pkg, oal_mem, oal_seq.
//
//   channel  direction  handshake                 payload
//   request  in         i_in_valid / o_in_ready   i_in_req  (t_in_req)
//   result   out        o_out_valid / i_out_ready o_out_req (t_out_req)
//
// Refused requests, unused codes, search of an empty list, and insert or delete
// that need no shift finish without a pass over the entry memory.
// Insert with shift moves n = length - position entries.
// Delete with shift moves n = length - position - 1 entries.
// Search walks from index 0 to a match at index k, or over every entry on a miss;
// the walk goes through the single memory read port, one entry a cycle.
// Reset clears the length only; no clearing pass. A held result stalls the
// sequencer at its end, while one further request is still taken.
`timescale 1ns / 1ps

module ordered_array_list
    import oal_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          take;
    t_seq_res      seq_res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    logic          r_out_valid;
    t_out_req      r_out_req;

    assign take = !r_out_valid || i_out_ready;

    oal_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .i_take      (take),
        .o_seq_res   (seq_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    oal_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_res.done && take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res.done && take) begin
            r_out_req <= seq_res.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule
